// ----- hw/rtl/nnps_pkg.sv -----
// Shared types, constants and helper function of the nearest-neighbour pixel scaler.
`default_nettype none

package nnps_pkg;

   // Source position counters and size registers.
   localparam int CoordBits = 12;
   localparam int SizeW     = 13;
   localparam int OffsetW   = 12;
   localparam int PixelW    = 16;
   localparam int CsrIndexW = 3;
   localparam int MaxScale  = 8;
   localparam int SizeLimit = 4096;

   // Mapping divider: numerator is s * d + n - 1, quotient two bits per step.
   localparam int MapSW     = CoordBits + 1;
   localparam int ProdW     = MapSW + SizeW;
   localparam int NumW      = ProdW + 1;
   localparam int QuoW      = SizeW + 1;
   localparam int DivSteps  = QuoW / 2;
   localparam int StepW     = $clog2(DivSteps);
   localparam int RemW      = NumW - QuoW;

   // Command queue between the front and the back.
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // Colour conversion masks.
   localparam logic [PixelW-1:0] AlphaBit = 16'h8000;
   localparam logic [PixelW-1:0] RgMask   = 16'h7fe0;
   localparam logic [PixelW-1:0] BlueMask = 16'h001f;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_DST_LEFT   = 3'd4,
      CSR_DST_TOP    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MAP_IDLE,
      MAP_LOAD,
      MAP_DIV,
      MAP_FIN
   } map_state_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MAP,
      FRONT_HOLD
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic [PixelW-1:0] pixel_in;
      logic              frame_start;
   } req_word_type;

   typedef struct packed {
      logic [SizeW-1:0]  out_x;
      logic [SizeW-1:0]  out_y;
      logic [PixelW-1:0] out_color;
      logic              last_write;
   } rsp_word_type;

   // Effective sizes after clamping.
   typedef struct packed {
      logic [SizeW-1:0] src_w;
      logic [SizeW-1:0] src_h;
      logic [SizeW-1:0] dst_w;
      logic [SizeW-1:0] dst_h;
   } geom_type;

   // Destination rectangle covered by one source pixel.
   typedef struct packed {
      logic [SizeW-1:0]  x0;
      logic [SizeW-1:0]  x1;
      logic [SizeW-1:0]  y0;
      logic [SizeW-1:0]  y1;
      logic [PixelW-1:0] color;
   } cmd_type;

   // A size of zero counts as one; sizes above the limit saturate.
   function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
      logic [SizeW-1:0] r;
      if (v == '0) begin
         r = SizeW'(1);
      end else if (v > SizeW'(SizeLimit)) begin
         r = SizeW'(SizeLimit);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nnps_map_unit.sv -----
// Iterative mapping unit: min(d, ceil(s * d / n)), two quotient bits per cycle.
`default_nettype none

module nnps_map_unit
   import nnps_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MapSW-1:0] src_pos,
   input  wire logic [SizeW-1:0] dst_size,
   input  wire logic [SizeW-1:0] src_size,
   output logic                  done,
   output logic [SizeW-1:0]      result
);

   map_state_type      state_ff, state_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [ProdW-1:0]   prod_ff, prod_in;
   logic               over_ff, over_in;
   logic [SizeW-1:0]   d_ff, d_in;
   logic [SizeW-1:0]   n_ff, n_in;
   logic [SizeW+1:0]   n3_ff, n3_in;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic [QuoW-1:0]    quo_ff, quo_in;

   logic [NumW-1:0]    num;
   logic [RemW+1:0]    trial;
   logic [RemW+1:0]    n1_ext;
   logic [RemW+1:0]    n2_ext;
   logic [RemW+1:0]    n3_ext;
   logic [RemW+1:0]    diff;
   logic [1:0]         digit;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAP_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      over_ff <= over_in;
      d_ff    <= d_in;
      n_ff    <= n_in;
      n3_ff   <= n3_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // One radix-4 restoring division step.
   always_comb begin
      num    = NumW'(prod_ff) + NumW'(n_ff) - NumW'(1);
      trial  = {rem_ff, quo_ff[QuoW-1 -: 2]};
      n1_ext = (RemW + 2)'(n_ff);
      n2_ext = (RemW + 2)'({n_ff, 1'b0});
      n3_ext = (RemW + 2)'(n3_ff);
      if (trial >= n3_ext) begin
         digit = 2'd3;
         diff  = trial - n3_ext;
      end else if (trial >= n2_ext) begin
         digit = 2'd2;
         diff  = trial - n2_ext;
      end else if (trial >= n1_ext) begin
         digit = 2'd1;
         diff  = trial - n1_ext;
      end else begin
         digit = 2'd0;
         diff  = trial;
      end
   end

   // Sequencer: multiply, load numerator, divide, present result.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      over_in  = over_ff;
      d_in     = d_ff;
      n_in     = n_ff;
      n3_in    = n3_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (state_ff)
         MAP_IDLE: begin
            if (start) begin
               prod_in  = ProdW'(src_pos) * ProdW'(dst_size);
               over_in  = src_pos >= MapSW'(src_size);
               d_in     = dst_size;
               n_in     = src_size;
               n3_in    = (SizeW + 2)'(src_size) + (SizeW + 2)'({src_size, 1'b0});
               state_in = MAP_LOAD;
            end
         end
         MAP_LOAD: begin
            rem_in   = num[NumW-1:QuoW];
            quo_in   = num[QuoW-1:0];
            step_in  = '0;
            state_in = MAP_DIV;
         end
         MAP_DIV: begin
            rem_in  = diff[RemW-1:0];
            quo_in  = {quo_ff[QuoW-3:0], digit};
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(DivSteps - 1)) begin
               state_in = MAP_FIN;
            end
         end
         MAP_FIN: begin
            state_in = MAP_IDLE;
         end
         default: begin
            state_in = MAP_IDLE;
         end
      endcase
   end

   // A position at or past the source size maps to the destination size.
   assign done   = (state_ff == MAP_FIN);
   assign result = over_ff ? d_ff : quo_ff[SizeW-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/nnps_front.sv -----
// Front end: takes source pixels, tracks the source position and maps it to a rectangle.
`default_nettype none

module nnps_front
   import nnps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire req_word_type req_data,
   input  wire geom_type     geom,
   output logic              cmd_push,
   input  wire logic         cmd_full,
   output cmd_type           cmd_data
);

   front_state_type          state_ff, state_in;
   logic [CoordBits-1:0]     src_col_ff, src_col_in;
   logic [CoordBits-1:0]     src_row_ff, src_row_in;
   logic [PixelW-1:0]        color_ff, color_in;
   cmd_type                  cmd_ff, cmd_in;

   logic                     accept;
   logic [CoordBits-1:0]     cur_col;
   logic [CoordBits-1:0]     cur_row;
   logic [CoordBits-1:0]     col_inc;
   logic [CoordBits-1:0]     row_inc;
   logic [MapSW-1:0]         col_pos;
   logic [MapSW-1:0]         row_pos;
   logic [3:0]               lane_done;
   logic [SizeW-1:0]         x0, x1, y0, y1;
   logic                     all_done;
   logic                     range_empty;
   cmd_type                  lane_cmd;

   assign full   = (state_ff != FRONT_IDLE);
   assign accept = push && !full;

   // Source position of this pixel, and of the next one.
   always_comb begin
      cur_col = req_data.frame_start ? '0 : src_col_ff;
      cur_row = req_data.frame_start ? '0 : src_row_ff;
      col_inc = cur_col + CoordBits'(1);
      row_inc = cur_row + CoordBits'(1);
      col_pos = MapSW'(cur_col);
      row_pos = MapSW'(cur_row);
   end

   // Four mapping lanes: first and end columns, first and end rows.
   nnps_map_unit u_map_x0 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .src_pos  (col_pos),
      .dst_size (geom.dst_w),
      .src_size (geom.src_w),
      .done     (lane_done[0]),
      .result   (x0)
   );

   nnps_map_unit u_map_x1 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .src_pos  (col_pos + MapSW'(1)),
      .dst_size (geom.dst_w),
      .src_size (geom.src_w),
      .done     (lane_done[1]),
      .result   (x1)
   );

   nnps_map_unit u_map_y0 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .src_pos  (row_pos),
      .dst_size (geom.dst_h),
      .src_size (geom.src_h),
      .done     (lane_done[2]),
      .result   (y0)
   );

   nnps_map_unit u_map_y1 (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .src_pos  (row_pos + MapSW'(1)),
      .dst_size (geom.dst_h),
      .src_size (geom.src_h),
      .done     (lane_done[3]),
      .result   (y1)
   );

   always_comb begin
      all_done       = &lane_done;
      range_empty    = (x0 == x1) || (y0 == y1);
      lane_cmd.x0    = x0;
      lane_cmd.x1    = x1;
      lane_cmd.y0    = y0;
      lane_cmd.y1    = y1;
      lane_cmd.color = color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FRONT_IDLE;
         src_col_ff <= '0;
         src_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      cmd_ff   <= cmd_in;
   end

   // Sequencer: accept, wait for the lanes, hand a non-empty rectangle to the queue or drop an empty one.
   always_comb begin
      state_in   = state_ff;
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      color_in   = color_ff;
      cmd_in     = cmd_ff;
      cmd_push   = 1'b0;
      cmd_data   = lane_cmd;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               color_in = AlphaBit | ((req_data.pixel_in >> 1) & RgMask)
                        | (req_data.pixel_in & BlueMask);
               // Raster advance; a column or row past the size wraps to zero.
               if ((MapSW'(col_inc) >= MapSW'(geom.src_w)) || (col_inc == '0)) begin
                  src_col_in = '0;
                  if (MapSW'(row_inc) >= MapSW'(geom.src_h)) begin
                     src_row_in = '0;
                  end else begin
                     src_row_in = row_inc;
                  end
               end else begin
                  src_col_in = col_inc;
                  src_row_in = cur_row;
               end
               state_in = FRONT_MAP;
            end
         end
         FRONT_MAP: begin
            if (all_done) begin
               cmd_in = lane_cmd;
               if (range_empty) begin
                  state_in = FRONT_IDLE;
               end else if (!cmd_full) begin
                  cmd_push = 1'b1;
                  state_in = FRONT_IDLE;
               end else begin
                  state_in = FRONT_HOLD;
               end
            end
         end
         FRONT_HOLD: begin
            cmd_data = cmd_ff;
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nnps_cmd_queue.sv -----
// Short command queue between the front end and the write generator.
`default_nettype none

module nnps_cmd_queue
   import nnps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_push,
   output logic         wr_full,
   input  wire cmd_type wr_data,
   input  wire logic    rd_pop,
   output logic         rd_empty,
   output cmd_type      rd_data
);

   cmd_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign wr_full  = (count_ff == QueueCntW'(QueueDepth));
   assign rd_empty = (count_ff == '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0
                   : wr_ptr_ff + QueuePtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0
                   : rd_ptr_ff + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nnps_back.sv -----
// Back end: walks each rectangle row by row and emits one write per cycle while its output is taken.
`default_nettype none

module nnps_back
   import nnps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_empty,
   output logic                    cmd_pop,
   input  wire cmd_type            cmd_data,
   input  wire logic [OffsetW-1:0] dst_left,
   input  wire logic [OffsetW-1:0] dst_top,
   output logic                    empty,
   input  wire logic               pop,
   output rsp_word_type            rsp_data
);

   back_state_type     state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_ff, out_in;
   cmd_type            cur_ff, cur_in;
   logic [SizeW-1:0]   x_ff, x_in;
   logic [SizeW-1:0]   y_ff, y_in;

   logic               out_free;
   logic [SizeW-1:0]   x_next;
   logic [SizeW-1:0]   y_next;
   logic               row_end;
   logic               last;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      x_next  = x_ff + SizeW'(1);
      y_next  = y_ff + SizeW'(1);
      row_end = (x_next == cur_ff.x1);
      last    = row_end && (y_next == cur_ff.y1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      cur_ff <= cur_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   // Write walker with an output register in front of the result port.
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cmd_pop      = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd_data;
               x_in     = cmd_data.x0;
               y_in     = cmd_data.y0;
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (out_free) begin
               out_valid_in      = 1'b1;
               out_in.out_x      = SizeW'(dst_left) + x_ff;
               out_in.out_y      = SizeW'(dst_top) + y_ff;
               out_in.out_color  = cur_ff.color;
               out_in.last_write = last;
               if (last) begin
                  // Move straight on to the next rectangle when one waits.
                  if (!cmd_empty) begin
                     cmd_pop = 1'b1;
                     cur_in  = cmd_data;
                     x_in    = cmd_data.x0;
                     y_in    = cmd_data.y0;
                  end else begin
                     state_in = BACK_IDLE;
                  end
               end else if (row_end) begin
                  x_in = cur_ff.x0;
                  y_in = y_next;
               end else begin
                  x_in = x_next;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_neighbour_pixel_scaler.sv -----
// Top level of the nearest-neighbour pixel scaler: registers, front end, queue and back end.
`default_nettype none

// Takes RGB565 source pixels in raster order and, for each, emits one A1R5G5B5
// write per destination pixel that maps to it, row by row, with the rectangle
// offset added and the last write of the pixel flagged. For each pixel the
// four mapping dividers, which work two quotient bits a cycle, load the
// numerator, divide and present the result, and the front end then hands the
// rectangle over, holding it while the queue is full; the back end produces
// one write per cycle while it has a rectangle and its output is taken. The
// two overlap through a two-entry queue; a pixel makes up to 64 writes at the
// largest scale. Sizes of zero count as one, sizes above 4096 saturate, and the
// destination is clamped to eight times the source. Write the registers only
// while idle.
module nearest_neighbour_pixel_scaler
   import nnps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [SizeW-1:0]     csr_wdata,
   input  wire logic                 push,
   output logic                      full,
   input  wire req_word_type         req_data,
   output logic                      empty,
   input  wire logic                 pop,
   output rsp_word_type              rsp_data
);

   logic [SizeW-1:0]     src_width_ff;
   logic [SizeW-1:0]     src_height_ff;
   logic [SizeW-1:0]     dst_width_ff;
   logic [SizeW-1:0]     dst_height_ff;
   logic [OffsetW-1:0]   dst_left_ff;
   logic [OffsetW-1:0]   dst_top_ff;

   logic [SizeW-1:0]     sw_eff;
   logic [SizeW-1:0]     sh_eff;
   logic [SizeW-1:0]     dw_clamp;
   logic [SizeW-1:0]     dh_clamp;
   logic [SizeW+2:0]     dw_limit;
   logic [SizeW+2:0]     dh_limit;
   geom_type             geom;

   logic                 q_push;
   logic                 q_full;
   cmd_type              q_wr_data;
   logic                 q_pop;
   logic                 q_empty;
   cmd_type              q_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SizeW'(256);
         src_height_ff <= SizeW'(224);
         dst_width_ff  <= SizeW'(256);
         dst_height_ff <= SizeW'(224);
         dst_left_ff   <= '0;
         dst_top_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            CSR_DST_LEFT:   dst_left_ff   <= csr_wdata[OffsetW-1:0];
            CSR_DST_TOP:    dst_top_ff    <= csr_wdata[OffsetW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective sizes; the destination never exceeds the maximum scale.
   always_comb begin
      sw_eff     = clamp_size(src_width_ff);
      sh_eff     = clamp_size(src_height_ff);
      dw_clamp   = clamp_size(dst_width_ff);
      dh_clamp   = clamp_size(dst_height_ff);
      dw_limit   = (SizeW + 3)'(MaxScale) * (SizeW + 3)'(sw_eff);
      dh_limit   = (SizeW + 3)'(MaxScale) * (SizeW + 3)'(sh_eff);
      geom.src_w = sw_eff;
      geom.src_h = sh_eff;
      geom.dst_w = ((SizeW + 3)'(dw_clamp) > dw_limit) ? dw_limit[SizeW-1:0] : dw_clamp;
      geom.dst_h = ((SizeW + 3)'(dh_clamp) > dh_limit) ? dh_limit[SizeW-1:0] : dh_clamp;
   end

   nnps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .geom     (geom),
      .cmd_push (q_push),
      .cmd_full (q_full),
      .cmd_data (q_wr_data)
   );

   nnps_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (q_push),
      .wr_full  (q_full),
      .wr_data  (q_wr_data),
      .rd_pop   (q_pop),
      .rd_empty (q_empty),
      .rd_data  (q_rd_data)
   );

   nnps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .cmd_data  (q_rd_data),
      .dst_left  (dst_left_ff),
      .dst_top   (dst_top_ff),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   // A pixel being mapped blocks the next one.
   assert property (@(posedge clock) disable iff (reset) (push && !full) |=> full)
      else $error("input taken while the front end was still mapping");

endmodule

`default_nettype wire
